/* src/bounded_lifo_stack_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the bounded LIFO stack
// Shorthands for clocked, reset-qualified implication checks.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_LIFO_STACK_ASSERT_SVH
`define BOUNDED_LIFO_STACK_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BLIFO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLIFO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/blifo_pkg.sv */
// ---------------------------------------------------------------------------
// blifo_pkg
// Shared constants, codes and control/status types of the LIFO stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package blifo_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_BITS    = 2;
    localparam int DATA_BITS   = 32;
    localparam int COUNT_BITS  = 5;
    localparam int CAP_BITS    = 5;
    localparam int STATUS_BITS = 2;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SHOW = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_DATA  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic do_push;
        logic start_pop;
        logic start_show;
        logic load_full;
        logic load_empty;
        logic load_data;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic fin;
        logic out_free;
    } dp_status_t;

endpackage

/* src/blifo_ctrl.sv */
// ---------------------------------------------------------------------------
// blifo_ctrl
// Command decoder and sequencer: accepts requests and runs result streams.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blifo_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [blifo_pkg::CMD_BITS-1:0] command,
    input  blifo_pkg::dp_status_t         sts,
    output logic                          in_stall,
    output blifo_pkg::dp_cmd_t            ctl
);
    import blifo_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        accept     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                // take a request only when a status result could be registered
                in_stall = !sts.out_free;
                accept   = in_valid && sts.out_free;
                if (accept)
                begin
                    unique case (command)
                        CMD_PUSH:
                        begin
                            if (sts.full)
                                ctl.load_full = 1'b1;
                            else
                                ctl.do_push = 1'b1;
                        end
                        CMD_POP:
                        begin
                            if (sts.empty)
                                ctl.load_empty = 1'b1;
                            else
                            begin
                                ctl.start_pop = 1'b1;
                                state_next    = S_STREAM;
                            end
                        end
                        CMD_SHOW:
                        begin
                            if (sts.empty)
                                ctl.load_empty = 1'b1;
                            else
                            begin
                                ctl.start_show = 1'b1;
                                state_next     = S_STREAM;
                            end
                        end
                        default:
                        begin
                            // unused code: drop it
                        end
                    endcase
                end
            end
            S_STREAM:
            begin
                if (sts.out_free)
                begin
                    ctl.load_data = 1'b1;
                    if (sts.fin)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* src/blifo_dp.sv */
// ---------------------------------------------------------------------------
// blifo_dp
// Stack memory, fill count, capacity register, read pointer and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blifo_dp
#(
    parameter int DEPTH     = blifo_pkg::DEPTH_DEF,
    parameter int WORD_BITS = blifo_pkg::WORD_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic signed [blifo_pkg::DATA_BITS-1:0]  push_value,
    input  logic [blifo_pkg::COUNT_BITS-1:0]        show_count,
    input  logic                                    cfg_wr_en,
    input  logic [blifo_pkg::CAP_BITS-1:0]          cfg_wr_data,
    input  logic                                    out_stall,
    input  blifo_pkg::dp_cmd_t                      ctl,
    output blifo_pkg::dp_status_t                   sts,
    output logic                                    out_valid,
    output logic [blifo_pkg::STATUS_BITS-1:0]       status,
    output logic signed [blifo_pkg::DATA_BITS-1:0]  data_word,
    output logic                                    past_end,
    output logic                                    last
);
    import blifo_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW0 = (CW > COUNT_BITS) ? CW : COUNT_BITS;
    localparam int MW  = (MW0 > CAP_BITS) ? MW0 : CAP_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] wr_word;
    logic [DATA_BITS-1:0] rdata_ext;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       remain_reg, remain_next;
    logic                beyond_reg, beyond_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CAP_BITS-1:0] cap_reg;
    logic [CW-1:0]       count_dec;

    logic [MW-1:0] count_x, cap_x, show_x, depth_x, bound_x, show_sat_x, n_x;
    logic          show_beyond;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [DATA_BITS-1:0]   data_reg;
    logic                   past_end_reg;
    logic                   last_reg;

    generate
        if (WORD_BITS >= DATA_BITS)
        begin : g_wide
            assign wr_word   = WORD_BITS'(unsigned'(push_value));
            assign rdata_ext = rdata_reg[DATA_BITS-1:0];
        end
        else
        begin : g_narrow
            assign wr_word   = push_value[WORD_BITS-1:0];
            assign rdata_ext = {{(DATA_BITS-WORD_BITS){1'b0}}, rdata_reg};
        end
    endgenerate

    assign count_x    = MW'(count_reg);
    assign cap_x      = MW'(cap_reg);
    assign show_x     = MW'(show_count);
    assign depth_x    = MW'(DEPTH);
    assign bound_x    = (cap_x > depth_x) ? depth_x : cap_x;
    assign show_sat_x = (show_x > depth_x) ? depth_x : show_x;
    assign show_beyond = show_sat_x > count_x;
    assign n_x        = ((show_sat_x == '0) || show_beyond) ? count_x : show_sat_x;
    assign count_dec  = count_reg - CW'(1);

    assign sts.full     = count_x >= bound_x;
    assign sts.empty    = (count_reg == '0);
    assign sts.fin      = (remain_reg == CW'(1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        count_next  = count_reg;
        remain_next = remain_reg;
        beyond_next = beyond_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ctl.do_push)
            count_next = count_reg + CW'(1);
        if (ctl.start_pop)
        begin
            count_next  = count_dec;
            remain_next = CW'(1);
            beyond_next = 1'b0;
            rd_ptr_next = count_dec[AW-1:0];
        end
        if (ctl.start_show)
        begin
            remain_next = n_x[CW-1:0];
            beyond_next = show_beyond;
            rd_ptr_next = count_dec[AW-1:0];
        end
        if (ctl.load_data)
        begin
            // advance toward the bottom of the stack
            remain_next = remain_reg - CW'(1);
            rd_ptr_next = rd_ptr_reg - AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_push)
            mem[count_reg[AW-1:0]] <= wr_word;
        rdata_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            remain_reg    <= '0;
            beyond_reg    <= 1'b0;
            rd_ptr_reg    <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            remain_reg <= remain_next;
            beyond_reg <= beyond_next;
            rd_ptr_reg <= rd_ptr_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (ctl.load_full || ctl.load_empty || ctl.load_data)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_full)
        begin
            status_reg   <= ST_FULL;
            data_reg     <= '0;
            past_end_reg <= 1'b0;
            last_reg     <= 1'b1;
        end
        else if (ctl.load_empty)
        begin
            status_reg   <= ST_EMPTY;
            data_reg     <= '0;
            past_end_reg <= 1'b0;
            last_reg     <= 1'b1;
        end
        else if (ctl.load_data)
        begin
            status_reg   <= ST_DATA;
            data_reg     <= rdata_ext;
            past_end_reg <= sts.fin && beyond_reg;
            last_reg     <= sts.fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_word = data_reg;
    assign past_end  = past_end_reg;
    assign last      = last_reg;

endmodule

/* src/bounded_lifo_stack.sv */
// Bounded LIFO stack of signed words with push, pop and display requests.
// A successful push gives no result; a push onto a full stack, and a pop or
// display on an empty one, give a single status result registered in the
// cycle after the request, and the next request may follow at once unless
// the output side stalls. A pop holds the input stalled until its word is
// loaded and returns the word through the memory read register and then the
// result register. A display of N entries stalls input until its last entry
// is loaded and streams one entry per cycle while the output side does not
// stall, top first; the pace is set by the single registered read port of
// the stack memory. The capacity register may be written only while no
// request is in progress.
// ---------------------------------------------------------------------------
// bounded_lifo_stack
// Top level: request decoder/sequencer plus stack datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_lifo_stack_assert.svh"

module bounded_lifo_stack
#(
    parameter int DEPTH     = blifo_pkg::DEPTH_DEF,
    parameter int WORD_BITS = blifo_pkg::WORD_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [blifo_pkg::CMD_BITS-1:0]          command,
    input  logic signed [blifo_pkg::DATA_BITS-1:0]  push_value,
    input  logic [blifo_pkg::COUNT_BITS-1:0]        show_count,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [blifo_pkg::STATUS_BITS-1:0]       status,
    output logic signed [blifo_pkg::DATA_BITS-1:0]  data_word,
    output logic                                    past_end,
    output logic                                    last,
    input  logic                                    cfg_wr_en,
    input  logic [blifo_pkg::CAP_BITS-1:0]          cfg_wr_data
);
    import blifo_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_sts;

    blifo_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .sts      (dp_sts),
        .in_stall (in_stall),
        .ctl      (dp_cmd)
    );

    blifo_dp
    #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_value  (push_value),
        .show_count  (show_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_stall   (out_stall),
        .ctl         (dp_cmd),
        .sts         (dp_sts),
        .out_valid   (out_valid),
        .status      (status),
        .data_word   (data_word),
        .past_end    (past_end),
        .last        (last)
    );

    `BLIFO_ASSERT_SAME(a_one_result_load, 1'b1, $onehot0({dp_cmd.load_full, dp_cmd.load_empty, dp_cmd.load_data}), "two result loads in one cycle")
    `BLIFO_ASSERT_SAME(a_push_not_full, dp_cmd.do_push, !dp_sts.full, "push written into a full stack")
    `BLIFO_ASSERT_SAME(a_stream_stalls_input, dp_cmd.load_data, in_stall, "input open during a result stream")
    `BLIFO_ASSERT_NEXT(a_pop_single_result, dp_cmd.start_pop, dp_sts.fin, "pop stream longer than one word")

endmodule
